@@ src/ppts_pkg.sv @@
package ppts_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W = 32;
  localparam int PROD_W = 2 * COORD_W;
  localparam int SHP_W = PROD_W - COORD_FRAC_BITS;
  localparam int CLIP_W = ((SHP_W > COORD_W) ? SHP_W : COORD_W) + 2;
  localparam int DIM_W = 13;
  localparam int SCR_W = DIM_W + 4;
  localparam int REM_W = CLIP_W + 2;

  // Largest clip w for which w * 1000 < 2^COORD_FRAC_BITS holds, so that the point is rejected.
  localparam logic signed [CLIP_W-1:0] W_REJECT_MAX =
    CLIP_W'(((2 ** COORD_FRAC_BITS) - 1) / 1000);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PROJECT = 1'b1;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef logic signed [CLIP_W-1:0] clip_t;
  typedef logic [CLIP_W-1:0] ratio_t;
  typedef logic [SCR_W-1:0] scr_t;

endpackage

@@ src/perspective_project_to_screen.sv @@
// Pipeline: two clip stages, one test stage and 17 divider stages, one per multiplier bit
// of the screen scale.
// Throughput: one transaction per cycle, but the whole pipeline halts while a finished
// result waits at the output. Matrix loads take effect at once and give no result.
// Reset (synchronous, active low) clears the matrix, the valid bits and sets the viewport to
// 1920 by 1080.
module perspective_project_to_screen (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [3:0]                          in_entry_index,
  input  logic signed [ppts_pkg::COORD_W-1:0] in_entry_value,
  input  logic signed [ppts_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [ppts_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [ppts_pkg::COORD_W-1:0] in_pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_visible,
  output logic [ppts_pkg::SCR_W-1:0]          out_screen_x,
  output logic [ppts_pkg::SCR_W-1:0]          out_screen_y,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ppts_pkg::DIM_W-1:0]          cfg_wdata
);
  import ppts_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic             en;
  logic             in_fire;
  logic             clip_vld;
  clip_t            cx, cy, cw;
  logic             t_vld_r, t_vis_r;
  ratio_t           nx_r, ny_r, d_r;
  logic             reject;
  logic             res_vld;

  assign en = !res_vld || out_ready;
  assign in_ready = en;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= DIM_W'(1920);
      height_r <= DIM_W'(1080);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  ppts_clip u_clip (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .load_fire   (in_fire && (in_func == FUNC_LOAD)),
    .proj_fire   (in_fire && (in_func == FUNC_PROJECT)),
    .entry_index (in_entry_index),
    .entry_value (in_entry_value),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .pos_z       (in_pos_z),
    .clip_vld    (clip_vld),
    .cx          (cx),
    .cy          (cy),
    .cw          (cw)
  );

  assign reject = (cw <= W_REJECT_MAX) || (cx < -cw) || (cx > cw) || (cy < -cw) || (cy > cw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (en) begin
      t_vld_r <= clip_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_vis_r <= !reject;
      nx_r <= ratio_t'(cx + cw);
      ny_r <= ratio_t'(cw - cy);
      d_r <= ratio_t'(cw) << 1;
    end
  end

  ppts_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (t_vld_r),
    .in_vis  (t_vis_r),
    .n_x     (nx_r),
    .n_y     (ny_r),
    .den     (d_r),
    .mult_x  ({width_r, 4'b0000}),
    .mult_y  ({height_r, 4'b0000}),
    .res_vld (res_vld),
    .res_vis (out_visible),
    .q_x     (out_screen_x),
    .q_y     (out_screen_y)
  );

  assign out_valid = res_vld;

  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_visible) |-> (out_screen_x == '0 && out_screen_y == '0))
    else $error("rejected point carries a non-zero screen position");

  a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visible) |-> (out_screen_x <= {width_r, 4'b0000}))
    else $error("screen x beyond the viewport width");

  a_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visible) |-> (out_screen_y <= {height_r, 4'b0000}))
    else $error("screen y beyond the viewport height");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_visible) && $stable(out_screen_x) && $stable(out_screen_y)))
    else $error("pipeline moved during an output stall");

  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result presented straight after reset");

endmodule

@@ src/ppts_clip.sv @@
module ppts_clip (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             load_fire,
  input  logic                             proj_fire,
  input  logic [3:0]                       entry_index,
  input  logic signed [ppts_pkg::COORD_W-1:0] entry_value,
  input  logic signed [ppts_pkg::COORD_W-1:0] pos_x,
  input  logic signed [ppts_pkg::COORD_W-1:0] pos_y,
  input  logic signed [ppts_pkg::COORD_W-1:0] pos_z,
  output logic                             clip_vld,
  output ppts_pkg::clip_t                  cx,
  output ppts_pkg::clip_t                  cy,
  output ppts_pkg::clip_t                  cw
);
  import ppts_pkg::*;

  logic signed [COORD_W-1:0] mat_r [16];
  logic signed [SHP_W-1:0]   prod_r [3][3];
  logic signed [COORD_W-1:0] ofs_r [3];
  logic                      s1_vld_r;
  logic                      s2_vld_r;
  clip_t                     cx_r, cy_r, cw_r;
  logic signed [SHP_W-1:0]   prod_nxt [3][3];
  logic signed [COORD_W-1:0] pos [3];

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  // Rows 0, 1 and 3 give clip x, y and w; products are floored to the coordinate format.
  always_comb begin
    logic signed [PROD_W-1:0] p;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p = PROD_W'(pos[c]) * PROD_W'(mat_r[((r == 2) ? 3 : r) * 4 + c]);
        prod_nxt[r][c] = p[PROD_W-1:COORD_FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= '0;
      end
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (load_fire) begin
        mat_r[entry_index] <= entry_value;
      end
      if (en) begin
        s1_vld_r <= proj_fire;
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= prod_nxt[r][c];
        end
        ofs_r[r] <= mat_r[((r == 2) ? 3 : r) * 4 + 3];
      end
      cx_r <= CLIP_W'(prod_r[0][0]) + CLIP_W'(prod_r[0][1]) + CLIP_W'(prod_r[0][2])
              + CLIP_W'(ofs_r[0]);
      cy_r <= CLIP_W'(prod_r[1][0]) + CLIP_W'(prod_r[1][1]) + CLIP_W'(prod_r[1][2])
              + CLIP_W'(ofs_r[1]);
      cw_r <= CLIP_W'(prod_r[2][0]) + CLIP_W'(prod_r[2][1]) + CLIP_W'(prod_r[2][2])
              + CLIP_W'(ofs_r[2]);
    end
  end

  assign clip_vld = s2_vld_r;
  assign cx = cx_r;
  assign cy = cy_r;
  assign cw = cw_r;

endmodule

@@ src/ppts_scale.sv @@
module ppts_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic              in_vis,
  input  ppts_pkg::ratio_t  n_x,
  input  ppts_pkg::ratio_t  n_y,
  input  ppts_pkg::ratio_t  den,
  input  ppts_pkg::scr_t    mult_x,
  input  ppts_pkg::scr_t    mult_y,
  output logic              res_vld,
  output logic              res_vis,
  output ppts_pkg::scr_t    q_x,
  output ppts_pkg::scr_t    q_y
);
  import ppts_pkg::*;

  localparam int NSTG = SCR_W;

  logic                   vld_r [NSTG];
  logic                   vis_r [NSTG];
  ratio_t                 nx_r [NSTG];
  ratio_t                 ny_r [NSTG];
  ratio_t                 d_r [NSTG];
  logic [REM_W-1:0]       rx_r [NSTG];
  logic [REM_W-1:0]       ry_r [NSTG];
  scr_t                   qx_r [NSTG];
  scr_t                   qy_r [NSTG];

  // One multiplier bit per stage: the remainder doubles, takes n if the bit is set, and
  // then loses d up to twice since it stays below three times d.
  function automatic logic [REM_W+1:0] div_step(logic [REM_W-1:0] r, ratio_t n,
                                               ratio_t d, logic b);
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] d1;
    logic [REM_W-1:0] d2;
    d1 = REM_W'(d);
    d2 = REM_W'(d) << 1;
    t = (r << 1) + (b ? REM_W'(n) : '0);
    if (t >= d2) begin
      return {2'd2, t - d2};
    end else if (t >= d1) begin
      return {2'd1, t - d1};
    end
    return {2'd0, t};
  endfunction

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic             p_vld, p_vis;
    ratio_t           p_nx, p_ny, p_d;
    logic [REM_W-1:0] p_rx, p_ry;
    scr_t             p_qx, p_qy;
    logic [REM_W+1:0] sx, sy;

    if (k == 0) begin : g_first
      assign p_vld = in_vld;
      assign p_vis = in_vis;
      assign p_nx = n_x;
      assign p_ny = n_y;
      assign p_d = den;
      assign p_rx = '0;
      assign p_ry = '0;
      assign p_qx = '0;
      assign p_qy = '0;
    end else begin : g_next
      assign p_vld = vld_r[k-1];
      assign p_vis = vis_r[k-1];
      assign p_nx = nx_r[k-1];
      assign p_ny = ny_r[k-1];
      assign p_d = d_r[k-1];
      assign p_rx = rx_r[k-1];
      assign p_ry = ry_r[k-1];
      assign p_qx = qx_r[k-1];
      assign p_qy = qy_r[k-1];
    end

    assign sx = div_step(p_rx, p_nx, p_d, mult_x[NSTG-1-k]);
    assign sy = div_step(p_ry, p_ny, p_d, mult_y[NSTG-1-k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vis_r[k] <= p_vis;
        nx_r[k] <= p_nx;
        ny_r[k] <= p_ny;
        d_r[k] <= p_d;
        rx_r[k] <= sx[REM_W-1:0];
        ry_r[k] <= sy[REM_W-1:0];
        qx_r[k] <= (p_qx << 1) + SCR_W'(sx[REM_W+1:REM_W]);
        qy_r[k] <= (p_qy << 1) + SCR_W'(sy[REM_W+1:REM_W]);
      end
    end
  end

  assign res_vld = vld_r[NSTG-1];
  assign res_vis = vis_r[NSTG-1];
  assign q_x = vis_r[NSTG-1] ? qx_r[NSTG-1] : '0;
  assign q_y = vis_r[NSTG-1] ? qy_r[NSTG-1] : '0;

endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppts_pkg::*;

  localparam int ONE = 1 << COORD_FRAC_BITS;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    logic       visible;
    logic [SCR_W-1:0] sx;
    logic [SCR_W-1:0] sy;
  } screen_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = FUNC_LOAD;
  logic [3:0] in_entry_index = '0;
  logic signed [COORD_W-1:0] in_entry_value = '0;
  logic signed [COORD_W-1:0] in_pos_x = '0;
  logic signed [COORD_W-1:0] in_pos_y = '0;
  logic signed [COORD_W-1:0] in_pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_visible;
  logic [SCR_W-1:0] out_screen_x;
  logic [SCR_W-1:0] out_screen_y;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_WIDTH;
  logic [DIM_W-1:0] cfg_wdata = '0;

  // Predictor state.
  longint view_mtx[16];
  longint width_px;
  longint height_px;
  screen_pt_t screen_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int stall_cnt;
  int err_cnt;

  perspective_project_to_screen i_dut (.*);

  always #2 clk = ~clk;

  function automatic screen_pt_t predict_screen(int x, int y, int z);
    screen_pt_t r;
    longint c[3];
    int rows[3];
    logic [127:0] num;
    logic [127:0] den;
    rows = '{0, 1, 3};
    r = '{1'b0, '0, '0};
    foreach (rows[k])
      c[k] = ((longint'(x) * view_mtx[rows[k]*4]) >>> COORD_FRAC_BITS) +
             ((longint'(y) * view_mtx[rows[k]*4+1]) >>> COORD_FRAC_BITS) +
             ((longint'(z) * view_mtx[rows[k]*4+2]) >>> COORD_FRAC_BITS) +
             view_mtx[rows[k]*4+3];
    if (c[2] * 1000 < longint'(ONE)) return r;
    if (c[0] < -c[2] || c[0] > c[2] || c[1] < -c[2] || c[1] > c[2]) return r;
    den = 128'(2 * c[2]);
    num = 128'(c[0] + c[2]) * 128'(width_px * 16);
    r.sx = SCR_W'(num / den);
    num = 128'(c[2] - c[1]) * 128'(height_px * 16);
    r.sy = SCR_W'(num / den);
    r.visible = 1'b1;
    return r;
  endfunction

  task automatic send_item(logic func, logic [3:0] idx, int val, int x, int y, int z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_func = func;
    in_entry_index = idx;
    in_entry_value = val;
    in_pos_x = x;
    in_pos_y = y;
    in_pos_z = z;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (func == FUNC_LOAD) view_mtx[idx] = longint'(val);
    else screen_q = {screen_q, predict_screen(x, y, z)};
    @(negedge clk);
  endtask

  task automatic load_entry(int idx, int val);
    send_item(FUNC_LOAD, 4'(idx), val, $urandom, $urandom, $urandom);
  endtask

  task automatic project(int x, int y, int z);
    send_item(FUNC_PROJECT, 4'($urandom), $urandom, x, y, z);
  endtask

  // Registers may only change once the pipeline has drained.
  task automatic write_viewport(int w, int h);
    in_valid = 1'b0;
    while (screen_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_WIDTH;
    cfg_wdata = DIM_W'(w);
    @(negedge clk);
    cfg_index = CFG_HEIGHT;
    cfg_wdata = DIM_W'(h);
    @(negedge clk);
    cfg_we = 1'b0;
    width_px = w;
    height_px = h;
  endtask

  function automatic int near_coord(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic test_directed();
    for (int i = 0; i < 16; i++) load_entry(i, 0);
    project(ONE, ONE, ONE);          // zero matrix: w is zero, so rejected
    load_entry(0, ONE);
    load_entry(5, ONE);
    load_entry(15, ONE);
    project(0, 0, 0);                // centre of the screen
    project(ONE, ONE, 0);            // on the right and top edges
    project(-ONE, -ONE, 0);          // on the left and bottom edges
    project(ONE + 1, 0, 0);          // just beyond the right edge
    project(0, -ONE - 1, 0);         // just beyond the bottom edge
    project(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    load_entry(15, 65);              // w just under the threshold
    project(0, 0, 0);
    load_entry(15, 66);              // w just over it
    project(0, 0, 0);
    load_entry(15, 32'h80000000);
    load_entry(14, 32'h7fffffff);
    project(-1, -1, 32'h80000000);
    load_entry(14, 0);
    load_entry(15, ONE);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 20) begin
        int idx;
        idx = $urandom_range(15);
        if ($urandom_range(9) == 0) load_entry(idx, $urandom);
        else if (idx == 15) load_entry(idx, $urandom_range(ONE / 4, 4 * ONE));
        else load_entry(idx, near_coord(ONE));
      end else if (pick < 30) begin
        project($urandom, $urandom, $urandom);
      end else begin
        project(near_coord(2 * ONE), near_coord(2 * ONE), near_coord(2 * ONE));
      end
    end
  endtask

  // The receiver stops for a long stretch while points keep coming.
  task automatic test_output_stall();
    hold_cycles = 300;
    for (int i = 0; i < 100; i++)
      project(near_coord(ONE), near_coord(ONE), near_coord(ONE));
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (screen_q.size() == 0) begin
        $error("result transaction with no projection pending");
        err_cnt++;
      end else begin
        screen_pt_t exp_pt;
        exp_pt = screen_q.pop_front();
        if (out_visible !== exp_pt.visible) begin
          $error("visible: expected %0d, got %0d", exp_pt.visible, out_visible);
          err_cnt++;
        end
        if (out_screen_x !== exp_pt.sx) begin
          $error("screen_x: expected %0d, got %0d", exp_pt.sx, out_screen_x);
          err_cnt++;
        end
        if (out_screen_y !== exp_pt.sy) begin
          $error("screen_y: expected %0d, got %0d", exp_pt.sy, out_screen_y);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    foreach (view_mtx[i]) view_mtx[i] = 0;
    width_px = 1920;
    height_px = 1080;
    hold_cycles = 0;
    stall_cnt = 0;
    err_cnt = 0;
    send_idle_pct = 31;
    recv_idle_pct = 48;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(300);
    write_viewport(1, 1);
    test_directed();
    test_random(300);
    send_idle_pct = 48;
    recv_idle_pct = 31;
    write_viewport(8191, 8191);
    test_random(300);
    test_output_stall();
    write_viewport(0, 0);
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_viewport($urandom_range(1, 8191), $urandom_range(1, 8191));
    test_random(400);
    write_viewport(1920, 1080);
    test_random(300);

    in_valid = 1'b0;
    while (screen_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
